// ----- rtl/tdq_pkg.sv -----
package tdq_pkg;

  // Default build-time values
  localparam int unsigned HISTORY_DEPTH_DEF    = 4;
  localparam int unsigned DEBOUNCE_POLLS_DEF   = 2;
  localparam int unsigned POLL_INTERVAL_MS_DEF = 10;

  // Fixed field widths
  localparam int unsigned POS_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RAW_W      = 32;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned PANEL_W    = 15;
  localparam int unsigned SRC_W      = 8;
  localparam int unsigned ROT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned KIND_W     = 2;

  // Streak counters saturate here
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Configuration reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = 15'd4;
  localparam logic [PANEL_W-1:0]  WIDTH_RST  = 15'd800;
  localparam logic [PANEL_W-1:0]  HEIGHT_RST = 15'd480;

  // Quarter turns
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOVE_THRESHOLD = 3'd0,
    CFG_ROTATION       = 3'd1,
    CFG_SWAP_AXES      = 3'd2,
    CFG_PANEL_WIDTH    = 3'd3,
    CFG_PANEL_HEIGHT   = 3'd4,
    CFG_SOURCE_NUMBER  = 3'd5
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_UP   = 2'd2
  } event_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_XFORM,
    ST_DECIDE,
    ST_SUM_CLR,
    ST_SUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_FIN,
    ST_SQ_DX,
    ST_SQ_DY,
    ST_SQ_T,
    ST_CMP,
    ST_EMIT
  } tdq_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CHECK,
    OP_XFORM,
    OP_SUM_CLR,
    OP_SUM,
    OP_DIV_INIT,
    OP_DIV,
    OP_DIV_FIN,
    OP_SQ_DX,
    OP_SQ_DY,
    OP_SQ_T,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    event_kind_e kind;
  } tdq_cmd_t;

  typedef struct packed {
    logic early;       // poll inside the interval, drop it
    logic pressed;
    logic is_down;
    logic press_ok;
    logic release_ok;
    logic sum_last;
    logic div_last;
    logic far;
    logic out_free;
  } tdq_sts_t;

endpackage

// ----- rtl/touch_event_qualifier_core.sv -----
// Touch event qualifier: turns touch controller polls into pointer events.
//
// Input stream: one poll per transfer. A poll less than POLL_INTERVAL_MS after
// the last kept poll (wrapping 32-bit time) is dropped without a result.
// Output stream: zero or one event per poll (down, move, up) with source id,
// poll time and position.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge; write only while the block is idle. Unknown indexes are ignored.
//
// One poll at a time: s_axis_tready is high only in the idle state. A dropped
// poll returns to idle from the gate check and a quiet poll from the decision;
// a down event also runs the serial history sum over the N stored samples and
// the bit-serial divider; a move then adds the shared squarer and compare; an
// up goes from the decision straight to the emit state.
// The result sits in an output register, so the next poll is taken while
// it waits; a stalled receiver only holds a later event in the emit state.
// Reset (rst_ni low, async) restores all config defaults, clears the
// tracking state and drops any pending output.
module touch_event_qualifier_core #(
  parameter int unsigned HISTORY_DEPTH    = tdq_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned DEBOUNCE_POLLS   = tdq_pkg::DEBOUNCE_POLLS_DEF,
  parameter int unsigned POLL_INTERVAL_MS = tdq_pkg::POLL_INTERVAL_MS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Poll channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // now_ms[31:0], raw_x[63:32], raw_y[95:64]
  input  logic [tdq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // touching[0]
  input  logic                            s_axis_tuser,
  // Event channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // event_source[7:0], event_time_ms[39:8], pos_x[55:40], pos_y[71:56]
  output logic [tdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // event_kind[1:0]
  output logic [tdq_pkg::KIND_W-1:0]      m_axis_tuser,
  // Config write port
  input  logic                            cfg_we_i,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tdq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import tdq_pkg::*;

  tdq_cmd_t cmd;
  tdq_sts_t sts;

  // Sequencer: walks each poll through gate, transform, average, distance, emit
  tdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Datapath: config, history, serial sum/divide, squarer, output register
  tdq_dp #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .DEBOUNCE_POLLS   (DEBOUNCE_POLLS),
    .POLL_INTERVAL_MS (POLL_INTERVAL_MS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

// ----- rtl/tdq_ctrl.sv -----
module tdq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output tdq_pkg::tdq_cmd_t cmd_o,
  input  tdq_pkg::tdq_sts_t sts_i
);
  import tdq_pkg::*;

  tdq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:    state_d = sts_i.early ? ST_IDLE : ST_XFORM;
      ST_XFORM:    state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (sts_i.pressed && (sts_i.is_down || sts_i.press_ok)) begin
          state_d = ST_SUM_CLR;
        end else if (!sts_i.pressed && sts_i.is_down && sts_i.release_ok) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_CLR:  state_d = ST_SUM;
      ST_SUM:      if (sts_i.sum_last) state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV:      if (sts_i.div_last) state_d = ST_DIV_FIN;
      ST_DIV_FIN:  state_d = sts_i.is_down ? ST_SQ_DX : ST_EMIT;
      ST_SQ_DX:    state_d = ST_SQ_DY;
      ST_SQ_DY:    state_d = ST_SQ_T;
      ST_SQ_T:     state_d = ST_CMP;
      ST_CMP:      state_d = sts_i.far ? ST_EMIT : ST_IDLE;
      ST_EMIT:     if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.kind  = KIND_DOWN;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_CHECK:    cmd_o.op = OP_CHECK;
      ST_XFORM:    cmd_o.op = OP_XFORM;
      ST_SUM_CLR:  cmd_o.op = OP_SUM_CLR;
      ST_SUM:      cmd_o.op = OP_SUM;
      ST_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_DIV_FIN:  cmd_o.op = OP_DIV_FIN;
      ST_SQ_DX:    cmd_o.op = OP_SQ_DX;
      ST_SQ_DY:    cmd_o.op = OP_SQ_DY;
      ST_SQ_T:     cmd_o.op = OP_SQ_T;
      ST_EMIT: begin
        if (sts_i.out_free) cmd_o.op = OP_EMIT;
        if (!sts_i.pressed) begin
          cmd_o.kind = KIND_UP;
        end else if (sts_i.is_down) begin
          cmd_o.kind = KIND_MOVE;
        end else begin
          cmd_o.kind = KIND_DOWN;
        end
      end
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/tdq_dp.sv -----
module tdq_dp #(
  parameter int unsigned HISTORY_DEPTH    = tdq_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned DEBOUNCE_POLLS   = tdq_pkg::DEBOUNCE_POLLS_DEF,
  parameter int unsigned POLL_INTERVAL_MS = tdq_pkg::POLL_INTERVAL_MS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [tdq_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic                               in_user_i,
  input  logic                               cfg_we_i,
  input  logic [tdq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tdq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  tdq_pkg::tdq_cmd_t                  cmd_i,
  output tdq_pkg::tdq_sts_t                  sts_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tdq_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [tdq_pkg::KIND_W-1:0]         out_user_o
);
  import tdq_pkg::*;

  localparam int unsigned CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned IDX_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUM_W     = POS_W + 1 + IDX_W;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);
  localparam int unsigned SQ_W      = 2 * (POS_W + 1);

  // Saturate a signed 32-bit coordinate to 16 bits
  function automatic logic signed [POS_W-1:0] clamp16(input logic signed [RAW_W-1:0] v);
    logic in_range;
    begin
      in_range = (v[RAW_W-1:POS_W-1] == '0) || (v[RAW_W-1:POS_W-1] == '1);
      if (in_range) begin
        clamp16 = v[POS_W-1:0];
      end else if (v[RAW_W-1]) begin
        clamp16 = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        clamp16 = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  endfunction

  // One restoring step: returns {remainder, quotient}
  function automatic logic [CNT_W+SUM_W-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                      input logic [SUM_W-1:0] quo,
                                                      input logic [CNT_W-1:0] dvs);
    logic [CNT_W:0]     r_sh;
    logic [SUM_W-1:0]   q_sh;
    logic [CNT_W:0]     r_sub;
    begin
      r_sh  = {rem, quo[SUM_W-1]};
      q_sh  = {quo[SUM_W-2:0], 1'b0};
      r_sub = r_sh - {1'b0, dvs};
      if (r_sh >= {1'b0, dvs}) begin
        div_step = {r_sub[CNT_W-1:0], q_sh[SUM_W-1:1], 1'b1};
      end else begin
        div_step = {r_sh[CNT_W-1:0], q_sh};
      end
    end
  endfunction

  // Configuration
  logic [THRESH_W-1:0] thresh_q;
  logic [ROT_W-1:0]    rot_q;
  logic                swap_q;
  logic [PANEL_W-1:0]  width_q, height_q;
  logic [SRC_W-1:0]    src_q;

  // Poll capture
  logic [TIME_W-1:0]        now_q;
  logic                     pressed_q;
  logic signed [RAW_W-1:0]  raw_x_q, raw_y_q;
  logic signed [POS_W-1:0]  x_q, y_q;

  // Tracking state
  logic [TIME_W-1:0]        last_poll_q;
  logic                     is_down_q;
  logic [RUN_W-1:0]         press_run_q, release_run_q;
  logic [CNT_W-1:0]         count_q;
  logic signed [POS_W-1:0]  cmt_x_q, cmt_y_q;
  logic signed [POS_W-1:0]  hist_x_q [HISTORY_DEPTH];
  logic signed [POS_W-1:0]  hist_y_q [HISTORY_DEPTH];

  // Averaging
  logic [IDX_W-1:0]         idx_q;
  logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
  logic [SUM_W-1:0]         quo_x_q, quo_y_q;
  logic [CNT_W-1:0]         rem_x_q, rem_y_q;
  logic                     neg_x_q, neg_y_q;
  logic [DIV_CNT_W-1:0]     div_cnt_q;
  logic signed [POS_W-1:0]  avg_x_q, avg_y_q;

  // Distance
  logic [SQ_W-1:0]          prod_q, acc_q;

  // Output register
  logic                     out_valid_q;
  logic [OUT_DATA_W-1:0]    out_data_q;
  logic [KIND_W-1:0]        out_user_q;

  // Combinational helpers
  logic [TIME_W-1:0]        elapsed;
  logic signed [POS_W-1:0]  cx, cy;
  logic signed [POS_W-1:0]  w16, h16;
  logic signed [POS_W-1:0]  rx, ry;
  logic [CNT_W+SUM_W-1:0]   step_x, step_y;
  logic signed [POS_W:0]    dx, dy, mul_a;
  logic signed [SQ_W-1:0]   sq;
  logic signed [POS_W-1:0]  emit_x, emit_y;

  assign elapsed = now_q - last_poll_q;
  assign cx      = clamp16(raw_x_q);
  assign cy      = clamp16(raw_y_q);
  assign w16     = {1'b0, width_q} - 16'sd1;
  assign h16     = {1'b0, height_q} - 16'sd1;

  always_comb begin
    case (rot_q)
      ROT_90: begin
        rx = h16 - y_q;
        ry = x_q;
      end
      ROT_180: begin
        rx = w16 - x_q;
        ry = h16 - y_q;
      end
      ROT_270: begin
        rx = y_q;
        ry = w16 - x_q;
      end
      default: begin
        rx = x_q;
        ry = y_q;
      end
    endcase
  end

  assign step_x = div_step(rem_x_q, quo_x_q, count_q);
  assign step_y = div_step(rem_y_q, quo_y_q, count_q);

  // One shared squarer
  assign dx = {avg_x_q[POS_W-1], avg_x_q} - {cmt_x_q[POS_W-1], cmt_x_q};
  assign dy = {avg_y_q[POS_W-1], avg_y_q} - {cmt_y_q[POS_W-1], cmt_y_q};
  always_comb begin
    case (cmd_i.op)
      OP_SQ_DX: mul_a = dx;
      OP_SQ_DY: mul_a = dy;
      default:  mul_a = {2'b00, thresh_q};
    endcase
  end
  assign sq = mul_a * mul_a;

  assign emit_x = (cmd_i.kind == KIND_UP) ? cmt_x_q : avg_x_q;
  assign emit_y = (cmd_i.kind == KIND_UP) ? cmt_y_q : avg_y_q;

  // Configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q      <= THRESH_RST;
      rot_q         <= '0;
      swap_q        <= 1'b0;
      width_q       <= WIDTH_RST;
      height_q      <= HEIGHT_RST;
      src_q         <= '0;
      last_poll_q   <= '0;
      is_down_q     <= 1'b0;
      press_run_q   <= '0;
      release_run_q <= '0;
      count_q       <= '0;
      cmt_x_q       <= '0;
      cmt_y_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MOVE_THRESHOLD: thresh_q <= cfg_data_i[THRESH_W-1:0];
          CFG_ROTATION:       rot_q    <= cfg_data_i[ROT_W-1:0];
          CFG_SWAP_AXES:      swap_q   <= cfg_data_i[0];
          CFG_PANEL_WIDTH:    width_q  <= cfg_data_i[PANEL_W-1:0];
          CFG_PANEL_HEIGHT:   height_q <= cfg_data_i[PANEL_W-1:0];
          CFG_SOURCE_NUMBER:  src_q    <= cfg_data_i[SRC_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.op == OP_CHECK && !sts_o.early) begin
        last_poll_q <= now_q;
      end

      if (cmd_i.op == OP_XFORM) begin
        if (pressed_q) begin
          if (count_q < CNT_W'(HISTORY_DEPTH)) count_q <= count_q + 1'b1;
          if (press_run_q != RUN_MAX) press_run_q <= press_run_q + 1'b1;
          release_run_q <= '0;
        end else begin
          count_q     <= '0;
          press_run_q <= '0;
          if (release_run_q != RUN_MAX) release_run_q <= release_run_q + 1'b1;
        end
      end

      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
        case (cmd_i.kind)
          KIND_DOWN: begin
            is_down_q <= 1'b1;
            cmt_x_q   <= avg_x_q;
            cmt_y_q   <= avg_y_q;
          end
          KIND_MOVE: begin
            cmt_x_q <= avg_x_q;
            cmt_y_q <= avg_y_q;
          end
          KIND_UP:   is_down_q <= 1'b0;
          default: ;
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        now_q     <= in_data_i[TIME_W-1:0];
        raw_x_q   <= in_data_i[TIME_W+RAW_W-1:TIME_W];
        raw_y_q   <= in_data_i[TIME_W+2*RAW_W-1:TIME_W+RAW_W];
        pressed_q <= in_user_i;
      end
      OP_CHECK: begin
        x_q <= swap_q ? cy : cx;
        y_q <= swap_q ? cx : cy;
      end
      OP_XFORM: begin
        if (pressed_q) begin
          for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_x_q[i] <= hist_x_q[i-1];
            hist_y_q[i] <= hist_y_q[i-1];
          end
          hist_x_q[0] <= rx;
          hist_y_q[0] <= ry;
        end
      end
      OP_SUM_CLR: begin
        sum_x_q <= '0;
        sum_y_q <= '0;
        idx_q   <= '0;
      end
      OP_SUM: begin
        sum_x_q <= sum_x_q + SUM_W'(hist_x_q[idx_q]);
        sum_y_q <= sum_y_q + SUM_W'(hist_y_q[idx_q]);
        idx_q   <= idx_q + 1'b1;
      end
      OP_DIV_INIT: begin
        neg_x_q   <= sum_x_q[SUM_W-1];
        neg_y_q   <= sum_y_q[SUM_W-1];
        quo_x_q   <= sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
        quo_y_q   <= sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
        rem_x_q   <= '0;
        rem_y_q   <= '0;
        div_cnt_q <= '0;
      end
      OP_DIV: begin
        {rem_x_q, quo_x_q} <= step_x;
        {rem_y_q, quo_y_q} <= step_y;
        div_cnt_q          <= div_cnt_q + 1'b1;
      end
      OP_DIV_FIN: begin
        avg_x_q <= neg_x_q ? -quo_x_q[POS_W-1:0] : quo_x_q[POS_W-1:0];
        avg_y_q <= neg_y_q ? -quo_y_q[POS_W-1:0] : quo_y_q[POS_W-1:0];
      end
      OP_SQ_DX: prod_q <= sq;
      OP_SQ_DY: begin
        acc_q  <= prod_q;
        prod_q <= sq;
      end
      OP_SQ_T: begin
        acc_q  <= acc_q + prod_q;
        prod_q <= sq;
      end
      OP_EMIT: begin
        out_user_q <= cmd_i.kind;
        out_data_q <= {emit_y, emit_x, now_q, src_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.early      = elapsed < TIME_W'(POLL_INTERVAL_MS);
    sts_o.pressed    = pressed_q;
    sts_o.is_down    = is_down_q;
    sts_o.press_ok   = press_run_q >= RUN_W'(DEBOUNCE_POLLS);
    sts_o.release_ok = release_run_q >= RUN_W'(DEBOUNCE_POLLS);
    sts_o.sum_last   = CNT_W'(idx_q) == (count_q - 1'b1);
    sts_o.div_last   = div_cnt_q == DIV_CNT_W'(SUM_W - 1);
    sts_o.far        = acc_q >= prod_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

// ----- rtl/tdq_checker.sv -----
module tdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tdq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic [tdq_pkg::KIND_W-1:0]      m_axis_tuser
);
  import tdq_pkg::*;

  // Held event stays put while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("event changed while stalled");

  // One poll in flight: ready drops right after a transfer
  a_one_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second poll taken while busy");

  // No event can appear the cycle after a poll transfer
  a_no_early_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("event appeared too soon after a poll");

  // Reset drops any pending event; checked at the edge after reset is sampled
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("event valid during reset");

endmodule

bind touch_event_qualifier_core tdq_checker u_tdq_checker (.*);
